>>> rtl/atq_pkg.sv
// Shared constants, types and tables for the accelerometer tilt quaternion block.
`default_nettype none
package atq_pkg;
    localparam int SAMPLE_WIDTH = 16;
    localparam int OUT_FRAC_BITS = 15;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int OUT_WIDTH = OUT_FRAC_BITS + 1;
    localparam int CW = 46;   // CORDIC datapath width
    localparam int AW = 34;   // angle width in the rotation units
    localparam int SCALE_SH = 41 - SAMPLE_WIDTH;

    // Magnitude of (2^30, 0) after the vectoring steps, i.e. the CORDIC gain in Q30.
    function automatic longint cordic_gain();
        longint x;
        longint y;
        longint dx;
        longint dy;
        begin
            x = 64'sd1 <<< 30;
            y = 64'sd0;
            for (int i = 0; i < CORDIC_ITERATIONS && i < 32; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x = x + dx;
                    y = y - dy;
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                end
            end
            return x;
        end
    endfunction

    localparam longint GAIN_Q30 = cordic_gain();

    // Gain and start value, fixed by the iteration count.
    localparam logic [CW-1:0] GAIN_Q20 = CW'(GAIN_Q30 >>> 10);
    localparam logic [CW-1:0] ROT_X0 = CW'((64'sd1 <<< 60) / GAIN_Q30);

    localparam logic [1:0] REG_MIN_MAG = 2'd0;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]          z;
    } vec_cell_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] z;
    } rot_cell_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E;
                5'd2: r = 32'h09FB385B; 5'd3: r = 32'h051111D4;
                5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
                5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55;
                5'd8: r = 32'h0028BE53; 5'd9: r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
                5'd30: r = 32'h00000001; default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

>>> rtl/atq_if.sv
// Valid/ready stream interfaces for samples and quaternions.
`default_nettype none
interface atq_sample_if;
    logic valid;
    logic ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atq_quat_if;
    logic valid;
    logic ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic degenerate;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, degenerate, input ready);
    modport sink (input valid, quat_w, quat_x, quat_y, quat_z, degenerate, output ready);
endinterface
`default_nettype wire

>>> rtl/accel_tilt_quaternion_top.sv
// Top level: pipelined CORDIC chain from an accelerometer sample to a tilt quaternion.
//
// channel   dir   payload
// sample    in    accel_x, accel_y, accel_z (signed 16)
// quat      out   quat_w/x/y/z (signed Q1.15), degenerate
// apb       in    min_magnitude_sq at byte address 0
//
// One sample per cycle enters while the pipeline advances; its result is presented after
// the roll chain, the pitch chain and the two rotation chains side by side, each N cells,
// plus six single register stages. The whole pipeline advances only when the output
// register is empty or being taken, so a stall at the sink holds every stage. Reset
// clears the valid bits and sets the floor register to one.
`default_nettype none
module accel_tilt_quaternion_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    atq_sample_if.sink       sample,
    atq_quat_if.source       quat,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int N = atq_pkg::CORDIC_ITERATIONS;
    localparam int CW = atq_pkg::CW;
    localparam int AW = atq_pkg::AW;
    localparam int DEPTH = 3 * N + 5;

    logic [31:0] min_mag_reg;
    logic        en;
    logic [DEPTH-1:0] vld_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == atq_pkg::REG_MIN_MAG) ? min_mag_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_mag_reg <= 32'd1;
        end
        else if (psel && penable && pwrite && paddr == atq_pkg::REG_MIN_MAG)
        begin
            min_mag_reg <= pwdata;
        end
    end

    assign en = !quat.valid || quat.ready;
    assign sample.ready = en;

    // Stage 0: scale, magnitude check, roll pre-rotation.
    logic signed [CW-1:0] ax_s, ay_s, az_s;
    logic [33:0] magsq;
    atq_pkg::vec_cell_t roll_in_reg;
    logic signed [CW-1:0] ax_reg;
    logic s0_degen_reg, s0_zero_reg;

    always_comb
    begin
        ax_s = CW'(sample.accel_x) <<< atq_pkg::SCALE_SH;
        ay_s = CW'(sample.accel_y) <<< atq_pkg::SCALE_SH;
        az_s = CW'(sample.accel_z) <<< atq_pkg::SCALE_SH;
        magsq = 34'($signed(sample.accel_x) * $signed(sample.accel_x))
              + 34'($signed(sample.accel_y) * $signed(sample.accel_y))
              + 34'($signed(sample.accel_z) * $signed(sample.accel_z));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_degen_reg <= magsq < {2'b00, min_mag_reg};
            s0_zero_reg <= (az_s == '0) && (ay_s == '0);
            ax_reg <= ax_s;
            if (az_s < 0)
            begin
                roll_in_reg.x <= -az_s;
                roll_in_reg.y <= -ay_s;
                roll_in_reg.z <= 32'h80000000;
            end
            else
            begin
                roll_in_reg.x <= az_s;
                roll_in_reg.y <= ay_s;
                roll_in_reg.z <= 32'd0;
            end
        end
    end

    // Roll vectoring chain.
    atq_pkg::vec_cell_t roll_c [0:N];
    assign roll_c[0] = roll_in_reg;
    logic signed [CW-1:0] axd_reg [0:N];
    logic degd_reg [0:N];
    logic zrd_reg [0:N];
    always_comb
    begin
        axd_reg[0] = ax_reg;
        degd_reg[0] = s0_degen_reg;
        zrd_reg[0] = s0_zero_reg;
    end
    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_roll
            atq_vec_cell u_cell (.clk(clk), .en(en), .shift(5'(g)),
                                 .din(roll_c[g]), .dout(roll_c[g+1]));
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    axd_reg[g+1] <= axd_reg[g];
                    degd_reg[g+1] <= degd_reg[g];
                    zrd_reg[g+1] <= zrd_reg[g];
                end
            end
        end
    endgenerate

    // Pitch y input: product with the gain, then the pitch input register and zero check.
    logic signed [CW-1:0] y2_reg;
    logic signed [CW-1:0] rk_reg;
    logic [31:0] roll_ang_reg;
    logic p0_deg_reg;
    logic signed [CW+21:0] prod_y;
    assign prod_y = (CW+22)'(-axd_reg[N]) * $signed({22'd0, atq_pkg::GAIN_Q20});
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y2_reg <= CW'(prod_y >>> 20);
            rk_reg <= zrd_reg[N] ? '0 : roll_c[N].x;
            roll_ang_reg <= zrd_reg[N] ? 32'd0 : roll_c[N].z;
            p0_deg_reg <= degd_reg[N];
        end
    end

    atq_pkg::vec_cell_t pitch_in_reg;
    logic [31:0] roll_ang2_reg;
    logic p1_deg_reg, p1_zero_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pitch_in_reg.x <= rk_reg;
            pitch_in_reg.y <= y2_reg;
            pitch_in_reg.z <= 32'd0;
            roll_ang2_reg <= roll_ang_reg;
            p1_deg_reg <= p0_deg_reg;
            p1_zero_reg <= (rk_reg == '0) && (y2_reg == '0);
        end
    end

    atq_pkg::vec_cell_t pitch_c [0:N];
    assign pitch_c[0] = pitch_in_reg;
    logic [31:0] rad_reg [0:N];
    logic pdeg_reg [0:N];
    logic pzr_reg [0:N];
    always_comb
    begin
        rad_reg[0] = roll_ang2_reg;
        pdeg_reg[0] = p1_deg_reg;
        pzr_reg[0] = p1_zero_reg;
    end
    generate
        for (g = 0; g < N; g++)
        begin : g_pitch
            atq_vec_cell u_cell (.clk(clk), .en(en), .shift(5'(g)),
                                 .din(pitch_c[g]), .dout(pitch_c[g+1]));
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[g+1] <= rad_reg[g];
                    pdeg_reg[g+1] <= pdeg_reg[g];
                    pzr_reg[g+1] <= pzr_reg[g];
                end
            end
        end
    endgenerate

    // Half angles; an angle of exactly half a turn counts as positive.
    function automatic logic signed [AW-1:0] half(input logic [31:0] a);
        logic signed [AW-1:0] v;
        begin
            if (a <= 32'h80000000)
            begin
                v = AW'({2'b00, a});
            end
            else
            begin
                v = AW'({2'b00, a}) - AW'(35'h100000000);
            end
            return v >>> 1;
        end
    endfunction

    atq_pkg::rot_cell_t rr_c [0:N];
    atq_pkg::rot_cell_t rp_c [0:N];
    logic rdeg_reg [0:N];
    logic [31:0] pang;
    assign pang = pzr_reg[N] ? 32'd0 : pitch_c[N].z;
    atq_pkg::rot_cell_t rr_in_reg, rp_in_reg;
    logic h_deg_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rr_in_reg.x <= atq_pkg::ROT_X0;
            rr_in_reg.y <= '0;
            rr_in_reg.z <= half(rad_reg[N]);
            rp_in_reg.x <= atq_pkg::ROT_X0;
            rp_in_reg.y <= '0;
            rp_in_reg.z <= half(pang);
            h_deg_reg <= pdeg_reg[N];
        end
    end
    always_comb
    begin
        rr_c[0] = rr_in_reg;
        rp_c[0] = rp_in_reg;
        rdeg_reg[0] = h_deg_reg;
    end
    generate
        for (g = 0; g < N; g++)
        begin : g_rot
            atq_rot_cell u_rr (.clk(clk), .en(en), .shift(5'(g)),
                               .din(rr_c[g]), .dout(rr_c[g+1]));
            atq_rot_cell u_rp (.clk(clk), .en(en), .shift(5'(g)),
                               .din(rp_c[g]), .dout(rp_c[g+1]));
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rdeg_reg[g+1] <= rdeg_reg[g];
                end
            end
        end
    endgenerate

    // Trig values are Q30 and fit in 32 bits; products are registered, then rounded.
    logic signed [31:0] cr, sr, cp, sp;
    assign cr = 32'(rr_c[N].x);
    assign sr = 32'(rr_c[N].y);
    assign cp = 32'(rp_c[N].x);
    assign sp = 32'(rp_c[N].y);
    logic signed [63:0] pw_reg, px_reg, py_reg, pz_reg;
    logic m_deg_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pw_reg <= 64'(cr) * 64'(cp);
            px_reg <= 64'(sr) * 64'(cp);
            py_reg <= 64'(cr) * 64'(sp);
            pz_reg <= -(64'(sr) * 64'(sp));
            m_deg_reg <= rdeg_reg[N];
        end
    end

    localparam int RSH = 60 - atq_pkg::OUT_FRAC_BITS;
    function automatic logic signed [15:0] to_out(input logic signed [63:0] p);
        logic signed [63:0] r;
        begin
            r = (p + (64'sd1 <<< (RSH - 1))) >>> RSH;
            if (r > 64'sd32767)
            begin
                r = 64'sd32767;
            end
            else if (r < -64'sd32768)
            begin
                r = -64'sd32768;
            end
            return r[15:0];
        end
    endfunction

    // Valid chain and the output register.
    logic vin;
    assign vin = sample.valid;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            quat.valid <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], vin};
            quat.valid <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quat.degenerate <= m_deg_reg;
            if (m_deg_reg)
            begin
                quat.quat_w <= 16'sd32767;
                quat.quat_x <= '0;
                quat.quat_y <= '0;
                quat.quat_z <= '0;
            end
            else
            begin
                quat.quat_w <= to_out(pw_reg);
                quat.quat_x <= to_out(px_reg);
                quat.quat_y <= to_out(py_reg);
                quat.quat_z <= to_out(pz_reg);
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/atq_vec_cell.sv
// One vectoring CORDIC micro-rotation with a pipeline register.
`default_nettype none
module atq_vec_cell (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [4:0]          shift,
    input  atq_pkg::vec_cell_t       din,
    output atq_pkg::vec_cell_t       dout
);
    atq_pkg::vec_cell_t res_next;
    atq_pkg::vec_cell_t res_reg;
    logic signed [atq_pkg::CW-1:0] dx;
    logic signed [atq_pkg::CW-1:0] dy;

    always_comb
    begin
        dx = din.y >>> shift;
        dy = din.x >>> shift;
        if (din.y > 0)
        begin
            res_next.x = din.x + dx;
            res_next.y = din.y - dy;
            res_next.z = din.z + atq_pkg::atan_lut(shift);
        end
        else
        begin
            res_next.x = din.x - dx;
            res_next.y = din.y + dy;
            res_next.z = din.z - atq_pkg::atan_lut(shift);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end
    assign dout = res_reg;
endmodule
`default_nettype wire

>>> rtl/atq_rot_cell.sv
// One rotation CORDIC micro-rotation with a pipeline register.
`default_nettype none
module atq_rot_cell (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [4:0]          shift,
    input  atq_pkg::rot_cell_t       din,
    output atq_pkg::rot_cell_t       dout
);
    atq_pkg::rot_cell_t res_next;
    atq_pkg::rot_cell_t res_reg;
    logic signed [atq_pkg::CW-1:0] dx;
    logic signed [atq_pkg::CW-1:0] dy;
    logic signed [atq_pkg::AW-1:0] at;

    always_comb
    begin
        dx = din.y >>> shift;
        dy = din.x >>> shift;
        at = atq_pkg::AW'({2'b00, atq_pkg::atan_lut(shift)});
        if (din.z >= 0)
        begin
            res_next.x = din.x - dx;
            res_next.y = din.y + dy;
            res_next.z = din.z - at;
        end
        else
        begin
            res_next.x = din.x + dx;
            res_next.y = din.y - dy;
            res_next.z = din.z + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end
    assign dout = res_reg;
endmodule
`default_nettype wire
